/* rtl/lpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_pkg : shared definitions for the Legendre value/derivative unit
// Widths, fixed-point constants, micro-op encoding and the step microcode.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Port field widths
  localparam int Z_W   = 32;
  localparam int DEG_W = 7;
  localparam int PV_W  = 32;
  localparam int DV_W  = 43;

  // Datapath widths
  localparam int FRAC_W  = 30;                       // Q30 fraction bits
  localparam int NAR_W   = 33;                       // narrow multiplier operand
  localparam int BIG_W   = 56;                       // wide operand, taken in chunks
  localparam int CHUNK_W = 28;                       // low chunk width
  localparam int PROD_W  = NAR_W + CHUNK_W + 1;
  localparam int ACC_W   = NAR_W + BIG_W + 1;
  localparam int Q_W     = ACC_W - FRAC_W;
  localparam int P_W     = 33;                       // running value, +-2.0
  localparam int PD_W    = 48;                       // running derivative, +-2^16
  localparam int T1_W    = 33;
  localparam int T2_W    = 48;
  localparam int NUM_W   = 41;
  localparam int NUMD_W  = 56;
  localparam int RECIP_W = 30;
  localparam int C_W     = DEG_W + 1;                // 2k+1
  localparam int STEP_W  = 4;

  localparam int LPD_MAX_DEGREE = 64;
  localparam int DEG_FIELD_MAX  = 2**DEG_W - 1;

  localparam logic [STEP_W-1:0] LAST_STEP = 4'd14;

  // Fixed-point constants
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_Q30    = 64'sd536870912;
  localparam longint VAL_INT_LIM = 64'sd2147483648;
  localparam longint DER_INT_LIM = 64'sd70368744177664;
  localparam longint DERIV_LIMIT = 64'sd2233382993920;

  // Narrow operand select
  typedef enum logic [2:0] {
    NS_Z, NS_T1, NS_P1, NS_P2, NS_C, NS_K, NS_R
  } nar_sel_t;

  // Wide operand select
  typedef enum logic [2:0] {
    BS_P2, BS_P2D, BS_C, BS_K, BS_T2, BS_P1D, BS_NUM, BS_NUMD
  } big_sel_t;

  // Write-back target (acc holds the result of an earlier op, after the product register and then the accumulator)
  typedef enum logic [2:0] {
    WB_NONE, WB_T1, WB_T2, WB_NUM, WB_NUMD, WB_P3, WB_P3D
  } wb_sel_t;

  typedef struct packed {
    nar_sel_t nar;
    big_sel_t big;
    logic     hi;      // high chunk of wide operand, weighted 2^28
    logic     first;   // first beat of an op: restart accumulator
    logic     sub;     // subtract the product
    logic     rnd;     // preload half LSB for Q30 rounding
    wb_sel_t  wb;
  } uop_t;

  typedef struct packed {
    logic             in_ready;
    logic             load;
    logic             run;
    logic             r_load;
    logic             emit;
    logic [DEG_W-1:0] k;
    uop_t             uop;
  } lpd_ctl_t;

  localparam uop_t UOP_NOP = '{NS_Z, BS_P2, 1'b0, 1'b0, 1'b0, 1'b0, WB_NONE};

  // One recurrence step: t1 = z*p2, t2 = z*p2d, num = c*t1 - k*p1,
  // numd = c*p2 + c*t2 - k*p1d, p3 = r*num, p3d = r*numd.
  function automatic uop_t lpd_ucode(input logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      4'd0:  u = '{NS_Z,  BS_P2,   1'b0, 1'b1, 1'b0, 1'b1, WB_NONE};
      4'd1:  u = '{NS_Z,  BS_P2,   1'b1, 1'b0, 1'b0, 1'b0, WB_P3D};
      4'd2:  u = '{NS_Z,  BS_P2D,  1'b0, 1'b1, 1'b0, 1'b1, WB_NONE};
      4'd3:  u = '{NS_Z,  BS_P2D,  1'b1, 1'b0, 1'b0, 1'b0, WB_T1};
      4'd4:  u = '{NS_T1, BS_C,    1'b0, 1'b1, 1'b0, 1'b0, WB_NONE};
      4'd5:  u = '{NS_P1, BS_K,    1'b0, 1'b0, 1'b1, 1'b0, WB_T2};
      4'd6:  u = '{NS_P2, BS_C,    1'b0, 1'b1, 1'b0, 1'b0, WB_NONE};
      4'd7:  u = '{NS_C,  BS_T2,   1'b0, 1'b0, 1'b0, 1'b0, WB_NUM};
      4'd8:  u = '{NS_C,  BS_T2,   1'b1, 1'b0, 1'b0, 1'b0, WB_NONE};
      4'd9:  u = '{NS_K,  BS_P1D,  1'b0, 1'b0, 1'b1, 1'b0, WB_NONE};
      4'd10: u = '{NS_K,  BS_P1D,  1'b1, 1'b0, 1'b1, 1'b0, WB_NONE};
      4'd11: u = '{NS_R,  BS_NUM,  1'b0, 1'b1, 1'b0, 1'b1, WB_NONE};
      4'd12: u = '{NS_R,  BS_NUM,  1'b1, 1'b0, 1'b0, 1'b0, WB_NUMD};
      4'd13: u = '{NS_R,  BS_NUMD, 1'b0, 1'b1, 1'b0, 1'b1, WB_NONE};
      4'd14: u = '{NS_R,  BS_NUMD, 1'b1, 1'b0, 1'b0, 1'b0, WB_P3};
      default: u = UOP_NOP;
    endcase
    return u;
  endfunction

endpackage

/* rtl/lpd_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_ifs : stream interfaces of the Legendre value/derivative unit
// Valid/ready channels; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface lpd_in_if;
  import lpd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [Z_W-1:0]   z_value;
  logic        [DEG_W-1:0] degree;

  modport source (output valid, z_value, degree, input ready);
  modport sink   (input valid, z_value, degree, output ready);
endinterface

interface lpd_out_if;
  import lpd_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PV_W-1:0] poly_value;
  logic signed [DV_W-1:0] deriv_value;

  modport source (output valid, poly_value, deriv_value, input ready);
  modport sink   (input valid, poly_value, deriv_value, output ready);
endinterface

/* rtl/lpd_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_mac : shared multiply-accumulate unit
// 33 x 29 signed multiply into a product register, then a 90-bit accumulate.
// ----------------------------------------------------------------------------
module lpd_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  lpd_pkg::uop_t                 uop,
  input  logic signed [lpd_pkg::NAR_W-1:0] nar,
  input  logic signed [lpd_pkg::BIG_W-1:0] big,
  output logic signed [lpd_pkg::ACC_W-1:0] acc
);
  import lpd_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(HALF_Q30);

  logic signed [CHUNK_W:0]   chunk_w;
  logic signed [PROD_W-1:0]  prod_w;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      en_r, hi_r, first_r, sub_r, rnd_r;
  logic signed [ACC_W-1:0]   term_w, base_w, acc_nxt;
  logic signed [ACC_W-1:0]   acc_r;

  // low chunk is unsigned, high chunk carries the sign
  assign chunk_w = uop.hi ? (CHUNK_W+1)'($signed(big[BIG_W-1:CHUNK_W]))
                          : $signed({1'b0, big[CHUNK_W-1:0]});
  assign prod_w  = PROD_W'(nar) * PROD_W'(chunk_w);

  assign term_w  = hi_r ? (ACC_W'(prod_r) <<< CHUNK_W) : ACC_W'(prod_r);
  assign base_w  = first_r ? (rnd_r ? ACC_HALF : '0) : acc_r;
  assign acc_nxt = sub_r ? (base_w - term_w) : (base_w + term_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else begin
      en_r <= en;
    end
    prod_r  <= prod_w;
    hi_r    <= uop.hi;
    first_r <= uop.first;
    sub_r   <= uop.sub;
    rnd_r   <= uop.rnd;
    if (en_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

/* rtl/lpd_recip_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_recip_rom : reciprocal table round(2^30 / d)
// Constant table built at elaboration, d = 2 .. effective max degree.
// ----------------------------------------------------------------------------
module lpd_recip_rom #(
  parameter int MAX_DEGREE = lpd_pkg::LPD_MAX_DEGREE
) (
  input  logic [lpd_pkg::DEG_W-1:0]   d,
  output logic [lpd_pkg::RECIP_W-1:0] recip
);
  import lpd_pkg::*;

  localparam int EFF_MAX = (MAX_DEGREE < DEG_FIELD_MAX) ? MAX_DEGREE : DEG_FIELD_MAX;
  localparam int TAB_AW  = $clog2(EFF_MAX + 1);
  localparam int TAB_N   = 2**TAB_AW;

  logic [RECIP_W-1:0] tab_w [TAB_N];

  for (genvar Gi = 0; Gi < TAB_N; Gi++) begin : g_tab
    if (Gi >= 2 && Gi <= EFF_MAX) begin : g_ent
      localparam logic [RECIP_W-1:0] RV =
        RECIP_W'((64'd2147483648 / 64'(Gi) + 64'd1) / 64'd2);
      assign tab_w[Gi] = RV;
    end else begin : g_nil
      assign tab_w[Gi] = '0;
    end
  end

  assign recip = tab_w[d[TAB_AW-1:0]];

endmodule

/* rtl/lpd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpd_ctrl : sequencer for the recurrence
// Steps 15 micro-ops per degree step, drains the MAC and hands off the beat.
// ----------------------------------------------------------------------------
module lpd_ctrl #(
  parameter int MAX_DEGREE = lpd_pkg::LPD_MAX_DEGREE
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [lpd_pkg::DEG_W-1:0] in_degree,
  input  logic                      out_free,
  output lpd_pkg::lpd_ctl_t         ctl
);
  import lpd_pkg::*;

  localparam int EFF_MAX = (MAX_DEGREE < DEG_FIELD_MAX) ? MAX_DEGREE : DEG_FIELD_MAX;
  localparam logic [DEG_W-1:0] DEG_CAP = DEG_W'(EFF_MAX);

  typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_WB, S_FIN} state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DEG_W-1:0]    k_r, k_nxt;
  logic [DEG_W-1:0]    n_r, n_nxt;
  logic [DEG_W-1:0]    n_in;
  logic                accept, last_iter;
  lpd_ctl_t            ctl_w;

  assign accept    = (state_r == S_IDLE) && in_valid;
  assign n_in      = (in_degree > DEG_CAP) ? DEG_CAP : in_degree;
  assign last_iter = (k_r == (n_r - DEG_W'(1)));

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt     = n_in;
          k_nxt     = DEG_W'(1);
          step_nxt  = '0;
          state_nxt = (n_in > DEG_W'(1)) ? S_RUN : S_FIN;
        end
      end
      S_RUN: begin
        if (step_r == LAST_STEP) begin
          step_nxt = '0;
          if (last_iter) begin
            state_nxt = S_DRAIN;
          end else begin
            k_nxt = k_r + DEG_W'(1);
          end
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_DRAIN: state_nxt = S_WB;
      S_WB:    state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_w          = '0;
    ctl_w.in_ready = (state_r == S_IDLE);
    ctl_w.load     = accept;
    ctl_w.run      = (state_r == S_RUN);
    ctl_w.r_load   = (state_r == S_RUN) && (step_r == '0);
    ctl_w.emit     = (state_r == S_FIN) && out_free;
    ctl_w.k        = k_r;
    ctl_w.uop      = UOP_NOP;
    if (state_r == S_RUN) begin
      ctl_w.uop = lpd_ucode(step_r);
      // no previous derivative step to retire on the first pass
      if (step_r == STEP_W'(1) && k_r == DEG_W'(1)) begin
        ctl_w.uop.wb = WB_NONE;
      end
    end else if (state_r == S_WB) begin
      ctl_w.uop.wb = WB_P3D;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      k_r     <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
    end
  end

  assign ctl = ctl_w;

endmodule

/* rtl/legendre_poly_and_derivative_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legendre_poly_and_derivative_unit : P_n(z) and P_n'(z) in fixed point
// Three-term recurrence on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Sequence: the input beat loads the operands; degree n >= 2 then runs n-1
//   degree steps of 15 micro-ops each on the single 33x29 multiplier, drains
//   the MAC and writes back the last derivative; degree 0 or 1 goes straight
//   to the output. A new input is taken only once the result has been emitted.
// Reset: synchronous, active low; clears sequencer, MAC enable and output
//   valid only.
// ----------------------------------------------------------------------------
module legendre_poly_and_derivative_unit #(
  parameter int MAX_DEGREE = lpd_pkg::LPD_MAX_DEGREE
) (
  input logic       clk,
  input logic       rst_n,
  lpd_in_if.sink    in_ch,
  lpd_out_if.source out_ch
);
  import lpd_pkg::*;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  lpd_ctl_t ctl;
  logic     out_valid_r;
  logic     out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  lpd_ctrl #(.MAX_DEGREE(MAX_DEGREE)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_degree (in_ch.degree),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  assign in_ch.ready = ctl.in_ready;

  // --------------------------------------------------------------------------
  // Operand registers
  //   p1/p2   : P_{k-1}, P_k          (Q30, held to +-2.0)
  //   p1d/p2d : P'_{k-1}, P'_k        (Q30, held to +-2^16)
  //   t1, t2  : z*P_k, z*P'_k         (rounded)
  //   num     : (2k+1) t1 - k P_{k-1} (exact)
  //   numd    : (2k+1)(P_k + t2) - k P'_{k-1}
  // --------------------------------------------------------------------------
  logic signed [Z_W-1:0]    z_r;
  logic signed [P_W-1:0]    p1_r, p2_r;
  logic signed [PD_W-1:0]   p1d_r, p2d_r;
  logic signed [T1_W-1:0]   t1_r;
  logic signed [T2_W-1:0]   t2_r;
  logic signed [NUM_W-1:0]  num_r;
  logic signed [NUMD_W-1:0] numd_r;
  logic        [RECIP_W-1:0] r_r;

  logic        [RECIP_W-1:0] recip_w;
  logic        [DEG_W-1:0]   d_w;
  logic        [C_W-1:0]     c_w;
  logic signed [Z_W-1:0]     zc_w;
  logic                      deg0_w;

  // 1/(k+1) for the current step
  assign d_w = ctl.k + DEG_W'(1);

  lpd_recip_rom #(.MAX_DEGREE(MAX_DEGREE)) u_rom (
    .d     (d_w),
    .recip (recip_w)
  );

  assign c_w = {ctl.k, 1'b1};   // 2k+1

  // input point pinned to [-1, 1]
  always_comb begin
    if (in_ch.z_value > Z_W'(ONE_Q30)) begin
      zc_w = Z_W'(ONE_Q30);
    end else if (in_ch.z_value < -Z_W'(ONE_Q30)) begin
      zc_w = -Z_W'(ONE_Q30);
    end else begin
      zc_w = in_ch.z_value;
    end
  end

  assign deg0_w = (in_ch.degree == '0);

  // --------------------------------------------------------------------------
  // Operand selection into the shared unit
  // --------------------------------------------------------------------------
  logic signed [NAR_W-1:0] nar_w;
  logic signed [BIG_W-1:0] big_w;
  logic signed [ACC_W-1:0] acc_w;

  always_comb begin
    unique case (ctl.uop.nar)
      NS_Z:    nar_w = NAR_W'(z_r);
      NS_T1:   nar_w = NAR_W'(t1_r);
      NS_P1:   nar_w = NAR_W'(p1_r);
      NS_P2:   nar_w = NAR_W'(p2_r);
      NS_C:    nar_w = $signed(NAR_W'(c_w));
      NS_K:    nar_w = $signed(NAR_W'(ctl.k));
      NS_R:    nar_w = $signed(NAR_W'(r_r));
      default: nar_w = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.uop.big)
      BS_P2:   big_w = BIG_W'(p2_r);
      BS_P2D:  big_w = BIG_W'(p2d_r);
      BS_C:    big_w = $signed(BIG_W'(c_w));
      BS_K:    big_w = $signed(BIG_W'(ctl.k));
      BS_T2:   big_w = BIG_W'(t2_r);
      BS_P1D:  big_w = BIG_W'(p1d_r);
      BS_NUM:  big_w = BIG_W'(num_r);
      BS_NUMD: big_w = BIG_W'(numd_r);
      default: big_w = '0;
    endcase
  end

  lpd_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (ctl.run),
    .uop   (ctl.uop),
    .nar   (nar_w),
    .big   (big_w),
    .acc   (acc_w)
  );

  // --------------------------------------------------------------------------
  // Write-back: Q30 rescale of the accumulator and the running-value limits
  // --------------------------------------------------------------------------
  localparam logic signed [Q_W-1:0] QV_HI = Q_W'(VAL_INT_LIM);
  localparam logic signed [Q_W-1:0] QD_HI = Q_W'(DER_INT_LIM);

  logic signed [Q_W-1:0] q_w, qv_w, qd_w;

  assign q_w = acc_w[ACC_W-1:FRAC_W];

  always_comb begin
    if (q_w > QV_HI) begin
      qv_w = QV_HI;
    end else if (q_w < -QV_HI) begin
      qv_w = -QV_HI;
    end else begin
      qv_w = q_w;
    end
    if (q_w > QD_HI) begin
      qd_w = QD_HI;
    end else if (q_w < -QD_HI) begin
      qd_w = -QD_HI;
    end else begin
      qd_w = q_w;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      // degree 0 starts (and ends) at P = 1, P' = 0
      z_r   <= zc_w;
      p1_r  <= P_W'(ONE_Q30);
      p2_r  <= deg0_w ? P_W'(ONE_Q30) : P_W'(zc_w);
      p1d_r <= '0;
      p2d_r <= deg0_w ? '0 : PD_W'(ONE_Q30);
    end else begin
      unique case (ctl.uop.wb)
        WB_NONE: ;
        WB_T1:   t1_r   <= q_w[T1_W-1:0];
        WB_T2:   t2_r   <= q_w[T2_W-1:0];
        WB_NUM:  num_r  <= acc_w[NUM_W-1:0];
        WB_NUMD: numd_r <= acc_w[NUMD_W-1:0];
        WB_P3: begin
          p1_r <= p2_r;
          p2_r <= qv_w[P_W-1:0];
        end
        WB_P3D: begin
          p1d_r <= p2d_r;
          p2d_r <= qd_w[PD_W-1:0];
        end
        default: ;
      endcase
    end
    if (ctl.r_load) begin
      r_r <= recip_w;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: final limits, P to [-1, 1], P' to +-2080
  // --------------------------------------------------------------------------
  logic signed [P_W-1:0]  pv_w;
  logic signed [PD_W-1:0] dv_w;
  logic signed [PV_W-1:0] poly_r;
  logic signed [DV_W-1:0] deriv_r;

  always_comb begin
    if (p2_r > P_W'(ONE_Q30)) begin
      pv_w = P_W'(ONE_Q30);
    end else if (p2_r < -P_W'(ONE_Q30)) begin
      pv_w = -P_W'(ONE_Q30);
    end else begin
      pv_w = p2_r;
    end
    if (p2d_r > PD_W'(DERIV_LIMIT)) begin
      dv_w = PD_W'(DERIV_LIMIT);
    end else if (p2d_r < -PD_W'(DERIV_LIMIT)) begin
      dv_w = -PD_W'(DERIV_LIMIT);
    end else begin
      dv_w = p2d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (ctl.emit) begin
      poly_r  <= pv_w[PV_W-1:0];
      deriv_r <= dv_w[DV_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.poly_value  = poly_r;
  assign out_ch.deriv_value = deriv_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  a_busy_while_run: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.run |-> !in_ch.ready)
    else $error("ready raised during recurrence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten before its beat left");

  a_wb_not_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.uop.wb != WB_NONE) |-> !ctl.load)
    else $error("write-back collides with operand load");

endmodule
